### hw/rtl/stev_pkg.sv
package stev_pkg;

    // Table geometry and number formats.
    localparam int MAX_KNOTS    = 64;
    localparam int IDX_W        = $clog2(MAX_KNOTS);
    localparam int KCOUNT_W     = 7;
    localparam int DATA_W       = 32;
    localparam int HALF_W       = 32;
    localparam int WIDE_W       = 64;
    localparam int PROD_W       = 2 * WIDE_W;
    localparam int FRAC_BITS    = 16;
    localparam int LIM_BIT      = 62;
    localparam int DIFF_W       = DATA_W + 1;
    localparam int NUM_W        = 2 * DIFF_W;
    localparam int CNT_W        = $clog2(NUM_W);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = KCOUNT_W;

    // Item kinds.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KCOUNT = 2'd2;

    // Mode codes.
    localparam logic INTERP_LINEAR = 1'b0;
    localparam logic INTERP_CUBIC  = 1'b1;
    localparam logic EXTRAP_LINEAR = 1'b0;
    localparam logic EXTRAP_FLAT   = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] knot_pos;
        logic signed [DATA_W-1:0] knot_val;
        logic signed [DATA_W-1:0] lin_coef;
        logic signed [DATA_W-1:0] quad_coef;
        logic signed [DATA_W-1:0] cube_coef;
        logic signed [DATA_W-1:0] query_pos;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_val;
        logic [IDX_W-1:0]         segment_index;
        logic                     saturated;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

    // One table entry as held in the knot memory.
    typedef struct packed {
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] lin;
        logic signed [DATA_W-1:0] quad;
        logic signed [DATA_W-1:0] cube;
    } entry_t;

endpackage

### hw/rtl/stev_ifs.sv
interface stev_req_if;
    import stev_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stev_rsp_if;
    import stev_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stev_cfg_if;
    import stev_pkg::*;
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/stev_mul.sv
module stev_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [stev_pkg::WIDE_W-1:0]  a,
    input  logic signed [stev_pkg::WIDE_W-1:0]  b,
    output logic                                done,
    output logic signed [stev_pkg::WIDE_W-1:0]  fx_res,
    output logic [stev_pkg::PROD_W-1:0]         prod,
    output logic                                neg
);
    import stev_pkg::*;

    localparam logic [2:0] PH_FIN = 3'd4;

    logic [WIDE_W-1:0]        ma_reg;
    logic [WIDE_W-1:0]        mb_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [2:0]               phase_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic                     neg_reg;
    logic signed [WIDE_W-1:0] res_reg;

    logic [HALF_W-1:0]        a_half;
    logic [HALF_W-1:0]        b_half;
    logic [WIDE_W-1:0]        pp;
    logic [1:0]               sh;
    logic [PROD_W-1:0]        pp_sh;
    logic                     big;
    logic                     frac;
    logic [WIDE_W-1:0]        mag;

    // One 32 by 32 partial product a cycle, shifted into place.
    always_comb
    begin
        a_half = phase_reg[1] ? ma_reg[WIDE_W-1:HALF_W] : ma_reg[HALF_W-1:0];
        b_half = phase_reg[0] ? mb_reg[WIDE_W-1:HALF_W] : mb_reg[HALF_W-1:0];
        pp     = a_half * b_half;
        sh     = {1'b0, phase_reg[1]} + {1'b0, phase_reg[0]};
        pp_sh  = {{(PROD_W-WIDE_W){1'b0}}, pp} << {sh, 5'd0};
    end

    // Scale by the fraction width, round toward minus infinity and clamp.
    always_comb
    begin
        big  = |acc_reg[PROD_W-1:LIM_BIT+FRAC_BITS];
        frac = |acc_reg[FRAC_BITS-1:0];
        if (big)
        begin
            mag = WIDE_W'(1) << LIM_BIT;
        end
        else
        begin
            mag = {{(WIDE_W-LIM_BIT){1'b0}}, acc_reg[LIM_BIT+FRAC_BITS-1:FRAC_BITS]}
                  + WIDE_W'(neg_reg && frac);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == PH_FIN)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= phase_reg + 3'd1;
                end
            end
        end
    end

    // Operand magnitudes, accumulator and result.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[WIDE_W-1] ? WIDE_W'(-a) : WIDE_W'(a);
            mb_reg  <= b[WIDE_W-1] ? WIDE_W'(-b) : WIDE_W'(b);
            neg_reg <= a[WIDE_W-1] ^ b[WIDE_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (phase_reg == PH_FIN)
            begin
                res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
            end
            else
            begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign done   = done_reg;
    assign fx_res = res_reg;
    assign prod   = acc_reg;
    assign neg    = neg_reg;

endmodule

### hw/rtl/stev_div.sv
module stev_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [stev_pkg::NUM_W-1:0]          num,
    input  logic [stev_pkg::DIFF_W-1:0]         den,
    input  logic                                neg,
    output logic                                done,
    output logic signed [stev_pkg::WIDE_W-1:0]  quot
);
    import stev_pkg::*;

    logic [NUM_W-1:0]         num_reg;
    logic [DIFF_W-1:0]        den_reg;
    logic [DIFF_W-1:0]        rem_reg;
    logic [NUM_W-1:0]         quot_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic                     neg_reg;
    logic signed [WIDE_W-1:0] res_reg;

    logic [DIFF_W:0]          trial;
    logic                     ge;
    logic [DIFF_W:0]          diff;
    logic [WIDE_W-1:0]        mag;

    // One restoring step a cycle.
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
        if (|quot_reg[NUM_W-1:LIM_BIT])
        begin
            mag = WIDE_W'(1) << LIM_BIT;
        end
        else
        begin
            mag = {{(WIDE_W-LIM_BIT){1'b0}}, quot_reg[LIM_BIT-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            neg_reg  <= neg;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= ge ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], ge};
        end
        else if (fin_reg)
        begin
            res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign done = done_reg;
    assign quot = res_reg;

endmodule

### hw/rtl/spline_table_evaluator_unit.sv
// Spline table evaluator. Knots (x, y, b, c, d in signed Q16.16) live in one
// synchronous memory of 64 entries with registered reads; a write beat fills
// one entry. A query beat runs one at a time: the segment search reads the
// memory once a cycle (one read for the left knot of the last segment, then
// up to n-2 reads scanning upward), FETL, FETR and FETG fetch the two knots,
// and SETUP sets up the segment. The shared 64 by 64 multiplier forms one
// 32 by 32 partial product a cycle and signals done with its result; cubic
// evaluation takes three steps inside or beyond the table end, one below it.
// Linear mode runs one product and a bit-serial divide, flat hold included; a
// flat hold in cubic mode and equal abscissas in linear mode skip the
// arithmetic. A finished result waits in S_FIN until the output register is
// free; it then waits in that register, and the next beat is taken once the
// result has been loaded there. No clearing pass is run after reset; entries
// must be written before a query reads them.
module spline_table_evaluator_unit (
    input  logic clk,
    input  logic rst_n,
    stev_req_if.sink   req,
    stev_rsp_if.source rsp,
    stev_cfg_if.sink   cfg
);
    import stev_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LCHK  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_FETL  = 4'd3;
    localparam logic [3:0] S_FETR  = 4'd4;
    localparam logic [3:0] S_FETG  = 4'd5;
    localparam logic [3:0] S_SETUP = 4'd6;
    localparam logic [3:0] S_CALC  = 4'd7;
    localparam logic [3:0] S_MULW  = 4'd8;
    localparam logic [3:0] S_LMULW = 4'd9;
    localparam logic [3:0] S_DIVW  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic [1:0] K_IN    = 2'd0;
    localparam logic [1:0] K_BELOW = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;

    // Knot memory.
    entry_t           tbl_mem [0:MAX_KNOTS-1];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;

    // Configuration.
    logic                interp_reg;
    logic                extrap_reg;
    logic [KCOUNT_W-1:0] kcount_reg;
    logic [IDX_W-1:0]    last_idx;

    // Control and working registers.
    logic [3:0]               state_reg, state_next;
    logic [IDX_W-1:0]         seg_reg, seg_next;
    logic [1:0]               kind_reg, kind_next;
    logic [1:0]               step_reg, step_next;
    logic signed [DATA_W-1:0] xx_reg, xx_next;
    entry_t                   left_reg, left_next;
    logic signed [DATA_W-1:0] xr_reg, xr_next;
    logic signed [DATA_W-1:0] yr_reg, yr_next;
    logic signed [WIDE_W-1:0] s_reg, s_next;
    logic signed [WIDE_W-1:0] wide_reg, wide_next;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;
    logic                     rsp_load;

    // Arithmetic units.
    logic                     mul_start;
    logic signed [WIDE_W-1:0] mul_a;
    logic signed [WIDE_W-1:0] mul_b;
    logic                     mul_done;
    logic signed [WIDE_W-1:0] mul_res;
    logic [PROD_W-1:0]        mul_prod;
    logic                     mul_neg;
    logic                     div_start;
    logic                     div_done;
    logic signed [WIDE_W-1:0] div_res;
    logic [DIFF_W-1:0]        den_mag;

    // Differences and step operands.
    logic signed [DIFF_W-1:0] dx_l;
    logic signed [DIFF_W-1:0] dx_r;
    logic signed [DIFF_W-1:0] d_lr;
    logic signed [DATA_W-1:0] ylf;
    logic signed [DATA_W-1:0] yrf;
    logic signed [DIFF_W-1:0] dy;
    logic signed [WIDE_W-1:0] h_sel;
    logic signed [WIDE_W-1:0] addend;
    logic signed [WIDE_W-1:0] scaled;
    logic                     last_step;
    logic                     sat_hi;
    logic                     sat_lo;

    stev_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .fx_res (mul_res),
        .prod   (mul_prod),
        .neg    (mul_neg)
    );

    stev_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod[NUM_W-1:0]),
        .den   (den_mag),
        .neg   (mul_neg ^ d_lr[DIFF_W-1]),
        .done  (div_done),
        .quot  (div_res)
    );

    // Knots in use, clamped to the table, less two.
    always_comb
    begin
        if (kcount_reg < KCOUNT_W'(2))
        begin
            last_idx = '0;
        end
        else if (kcount_reg > KCOUNT_W'(MAX_KNOTS))
        begin
            last_idx = IDX_W'(MAX_KNOTS - 2);
        end
        else
        begin
            last_idx = IDX_W'(kcount_reg - KCOUNT_W'(2));
        end
    end

    // Segment arithmetic operands.
    always_comb
    begin
        dx_l    = DIFF_W'(xx_reg) - DIFF_W'(left_reg.pos);
        dx_r    = DIFF_W'(xx_reg) - DIFF_W'(xr_reg);
        d_lr    = DIFF_W'(xr_reg) - DIFF_W'(left_reg.pos);
        den_mag = d_lr[DIFF_W-1] ? DIFF_W'(-d_lr) : DIFF_W'(d_lr);

        // Flat hold flattens the chord on either side.
        ylf = left_reg.val;
        yrf = yr_reg;
        if (extrap_reg == EXTRAP_FLAT)
        begin
            if (xx_reg < left_reg.pos)
            begin
                yrf = ylf;
            end
            if (xx_reg > xr_reg)
            begin
                ylf = yrf;
            end
        end
        dy = DIFF_W'(yrf) - DIFF_W'(ylf);

        // Per-step multiplier, addend and scale of the cubic evaluation.
        h_sel     = WIDE_W'(dx_l);
        addend    = WIDE_W'(left_reg.val);
        scaled    = mul_res;
        last_step = (step_reg == 2'd2);
        case (kind_reg)
            K_IN:
            begin
                case (step_reg)
                    2'd0:    addend = WIDE_W'(left_reg.quad);
                    2'd1:    addend = WIDE_W'(left_reg.lin);
                    default: addend = WIDE_W'(left_reg.val);
                endcase
            end
            K_BELOW:
            begin
                last_step = 1'b1;
            end
            K_END:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        h_sel  = WIDE_W'(d_lr);
                        addend = WIDE_W'(left_reg.quad) <<< 1;
                        scaled = mul_res + (mul_res <<< 1);
                    end
                    2'd1:
                    begin
                        h_sel  = WIDE_W'(d_lr);
                        addend = WIDE_W'(left_reg.lin);
                    end
                    default:
                    begin
                        h_sel  = WIDE_W'(dx_r);
                        addend = WIDE_W'(yr_reg);
                    end
                endcase
            end
            default:
            begin
                last_step = 1'b1;
            end
        endcase

        sat_hi = wide_reg > WIDE_W'(64'sh7FFF_FFFF);
        sat_lo = wide_reg < -WIDE_W'(64'sh8000_0000);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        xx_next    = xx_reg;
        left_next  = left_reg;
        xr_next    = xr_reg;
        yr_next    = yr_reg;
        s_next     = s_reg;
        wide_next  = wide_reg;
        rd_addr    = seg_reg;
        wr_en      = 1'b0;
        mul_start  = 1'b0;
        mul_a      = s_reg;
        mul_b      = h_sel;
        div_start  = 1'b0;
        rsp_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = last_idx;
                if (req.valid)
                begin
                    if (req.data.action == ACT_WRITE)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        xx_next    = req.data.query_pos;
                        state_next = S_LCHK;
                    end
                end
            end
            S_LCHK:
            begin
                if (xx_reg > rd_data_reg.pos)
                begin
                    seg_next   = last_idx;
                    state_next = S_FETL;
                end
                else
                begin
                    seg_next = '0;
                    rd_addr  = IDX_W'(1);
                    state_next = (last_idx == '0) ? S_FETL : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Data is the right knot of the current segment.
                rd_addr = seg_reg + IDX_W'(2);
                if (xx_reg > rd_data_reg.pos)
                begin
                    seg_next = seg_reg + IDX_W'(1);
                    if (seg_reg + IDX_W'(1) == last_idx)
                    begin
                        state_next = S_FETL;
                    end
                end
                else
                begin
                    state_next = S_FETL;
                end
            end
            S_FETL:
            begin
                state_next = S_FETR;
            end
            S_FETR:
            begin
                // Left knot arrives from the read issued in the cycle before.
                rd_addr    = seg_reg + IDX_W'(1);
                left_next  = rd_data_reg;
                state_next = S_FETG;
            end
            S_FETG:
            begin
                // Right knot lands in the cycle after the left one.
                xr_next    = rd_data_reg.pos;
                yr_next    = rd_data_reg.val;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                step_next = '0;
                if (interp_reg == INTERP_LINEAR)
                begin
                    if (xr_reg == left_reg.pos)
                    begin
                        wide_next  = WIDE_W'(ylf);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        s_next     = WIDE_W'(ylf);
                        mul_start  = 1'b1;
                        mul_a      = WIDE_W'(dy);
                        mul_b      = WIDE_W'(dx_l);
                        state_next = S_LMULW;
                    end
                end
                else if (xx_reg < left_reg.pos)
                begin
                    if (extrap_reg == EXTRAP_FLAT)
                    begin
                        wide_next  = WIDE_W'(left_reg.val);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        kind_next  = K_BELOW;
                        s_next     = WIDE_W'(left_reg.lin);
                        state_next = S_CALC;
                    end
                end
                else if (xx_reg > xr_reg)
                begin
                    if (extrap_reg == EXTRAP_FLAT)
                    begin
                        wide_next  = WIDE_W'(yr_reg);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        kind_next  = K_END;
                        s_next     = WIDE_W'(left_reg.cube);
                        state_next = S_CALC;
                    end
                end
                else
                begin
                    kind_next  = K_IN;
                    s_next     = WIDE_W'(left_reg.cube);
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                mul_start  = 1'b1;
                state_next = S_MULW;
            end
            S_MULW:
            begin
                if (mul_done)
                begin
                    if (last_step)
                    begin
                        wide_next  = scaled + addend;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        s_next     = scaled + addend;
                        step_next  = step_reg + 2'd1;
                        state_next = S_CALC;
                    end
                end
            end
            S_LMULW:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    wide_next  = s_reg + div_res;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Knot memory: one read a cycle alongside any write, with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[req.data.entry_index] <= '{pos:  req.data.knot_pos,
                                               val:  req.data.knot_val,
                                               lin:  req.data.lin_coef,
                                               quad: req.data.quad_coef,
                                               cube: req.data.cube_coef};
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            interp_reg    <= INTERP_LINEAR;
            extrap_reg    <= EXTRAP_LINEAR;
            kcount_reg    <= KCOUNT_W'(2);
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                case (cfg.data.index)
                    CFG_INTERP: interp_reg <= cfg.data.data[0];
                    CFG_EXTRAP: extrap_reg <= cfg.data.data[0];
                    CFG_KCOUNT: kcount_reg <= cfg.data.data;
                    default:    ;
                endcase
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_next;
        kind_reg <= kind_next;
        step_reg <= step_next;
        xx_reg   <= xx_next;
        left_reg <= left_next;
        xr_reg   <= xr_next;
        yr_reg   <= yr_next;
        s_reg    <= s_next;
        wide_reg <= wide_next;
        if (rsp_load)
        begin
            rsp_reg.segment_index <= seg_reg;
            rsp_reg.saturated     <= sat_hi || sat_lo;
            if (sat_hi)
            begin
                rsp_reg.result_val <= 32'sh7FFF_FFFF;
            end
            else if (sat_lo)
            begin
                rsp_reg.result_val <= 32'sh8000_0000;
            end
            else
            begin
                rsp_reg.result_val <= wide_reg[DATA_W-1:0];
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule
